### hw/rtl/crcfr_pkg.sv
// crcfr_pkg: types, codes and CRC-32 helpers for the CRC-32 frame receiver.
// Depends on nothing; used by the interfaces and the top level.
`timescale 1ns / 1ps
`default_nettype none

package crcfr_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned CODE_W   = 16;
    localparam int unsigned ARGS_W   = 8;
    localparam int unsigned ARRAY_W  = 16;
    localparam int unsigned LEN_W    = 16;
    localparam int unsigned FRAME_W  = 17;
    localparam int unsigned CRC_W    = 32;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 17;

    localparam logic [BYTE_W-1:0] START_BYTE = 8'h55;
    localparam logic [BYTE_W-1:0] END_BYTE   = 8'hAA;
    localparam logic [CRC_W-1:0]  CRC_INIT   = 32'hFFFF_FFFF;

    // bytes of framing around the payload: start, two length, four CRC, end
    localparam logic [FRAME_W-1:0] FRAME_OVERHEAD = 17'd8;
    localparam logic [LEN_W-1:0]   CRC_BYTES      = 16'd4;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_START_BAD = 3'd1;
    localparam logic [STATUS_W-1:0] ST_END_BAD   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_CRC_BAD   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_TOO_LONG  = 3'd5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAME = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ARGS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ARRAY = 2'd2;

    localparam logic [FRAME_W-1:0] MAX_FRAME_RST = 17'd65543;
    localparam logic [ARGS_W-1:0]  MAX_ARGS_RST  = 8'd255;
    localparam logic [ARRAY_W-1:0] MAX_ARRAY_RST = 16'd65535;

    typedef struct packed {
        logic [BYTE_W-1:0]   out_byte;
        logic                is_payload;
        logic [STATUS_W-1:0] status;
        logic [CODE_W-1:0]   frame_code;
        logic [ARGS_W-1:0]   arg_count;
        logic [ARRAY_W-1:0]  array_count;
        logic [LEN_W-1:0]    pay_len;
    } result_t;

    // reflected CRC-32, polynomial 0xEDB88320, one nibble per lookup
    function automatic logic [CRC_W-1:0] crc_nib_table(input logic [3:0] idx);
        logic [CRC_W-1:0] val;
        begin
            case (idx)
                4'h0:    val = 32'h0000_0000;
                4'h1:    val = 32'h1db7_1064;
                4'h2:    val = 32'h3b6e_20c8;
                4'h3:    val = 32'h26d9_30ac;
                4'h4:    val = 32'h76dc_4190;
                4'h5:    val = 32'h6b6b_51f4;
                4'h6:    val = 32'h4db2_6158;
                4'h7:    val = 32'h5005_713c;
                4'h8:    val = 32'hedb8_8320;
                4'h9:    val = 32'hf00f_9344;
                4'hA:    val = 32'hd6d6_a3e8;
                4'hB:    val = 32'hcb61_b38c;
                4'hC:    val = 32'h9b64_c2b0;
                4'hD:    val = 32'h86d3_d2d4;
                4'hE:    val = 32'ha00a_e278;
                4'hF:    val = 32'hbdbd_f21c;
                default: val = 32'h0000_0000;
            endcase
            return val;
        end
    endfunction

    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] mid;
        begin
            mid = crc_nib_table(crc[3:0] ^ b[3:0]) ^ (crc >> 4);
            return crc_nib_table(mid[3:0] ^ b[7:4]) ^ (mid >> 4);
        end
    endfunction

endpackage

`default_nettype wire

### hw/rtl/crcfr_ifs.sv
// crcfr_byte_if and crcfr_result_if: valid/ready channels of the frame receiver.
// Depends on crcfr_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface crcfr_byte_if;
    logic                            valid;
    logic                            ready;
    logic [crcfr_pkg::BYTE_W-1:0]    in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface crcfr_result_if;
    logic                            valid;
    logic                            ready;
    logic [crcfr_pkg::BYTE_W-1:0]    out_byte;
    logic                            is_payload;
    logic [crcfr_pkg::STATUS_W-1:0]  status;
    logic [crcfr_pkg::CODE_W-1:0]    frame_code;
    logic [crcfr_pkg::ARGS_W-1:0]    arg_count;
    logic [crcfr_pkg::ARRAY_W-1:0]   array_count;
    logic [crcfr_pkg::LEN_W-1:0]     pay_len;

    modport source (output valid, output out_byte, output is_payload, output status,
                    output frame_code, output arg_count, output array_count,
                    output pay_len, input ready);
    modport sink   (input valid, input out_byte, input is_payload, input status,
                    input frame_code, input arg_count, input array_count,
                    input pay_len, output ready);
endinterface

`default_nettype wire

### hw/rtl/crc32_frame_receiver.sv
// crc32_frame_receiver: a byte's result, if any, is registered and offered the next cycle.
// Throughput one byte per cycle: the frame state machine, CRC and head capture all update
// in the accept cycle; a single result register decouples the two channels and refills
// in the same cycle it is drained. Any byte stalls only while a result waits on a stalled sink.
// Reset (rst_n low, async): hunt for start byte, CRC all ones, limits at their maximum,
// result register empty. No clearing pass; the block is ready on the first cycle.
`timescale 1ns / 1ps
`default_nettype none

module crc32_frame_receiver (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [crcfr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [crcfr_pkg::CFG_DATA_W-1:0]   cfg_data,
    crcfr_byte_if.sink                              byte_ch,
    crcfr_result_if.source                          result_ch
);

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_LEN_HI  = 3'd1,
        PH_LEN_LO  = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_CRC     = 3'd4,
        PH_END     = 3'd5
    } phase_t;

    // frame state
    phase_t                              phase_reg, phase_next;
    logic [crcfr_pkg::LEN_W-1:0]         length_reg, length_next;
    logic [crcfr_pkg::LEN_W-1:0]         left_reg, left_next;
    logic [crcfr_pkg::CRC_W-1:0]         crc_reg, crc_next;
    logic [crcfr_pkg::CRC_W-1:0]         rx_crc_reg, rx_crc_next;
    logic [crcfr_pkg::CODE_W-1:0]        code_reg, code_next;
    logic [crcfr_pkg::ARGS_W-1:0]        args_reg, args_next;
    logic [crcfr_pkg::ARRAY_W-1:0]       array_reg, array_next;

    // configuration
    logic [crcfr_pkg::FRAME_W-1:0]       max_frame_reg;
    logic [crcfr_pkg::ARGS_W-1:0]        max_args_reg;
    logic [crcfr_pkg::ARRAY_W-1:0]       max_array_reg;

    // result register
    logic                                res_valid_reg;
    crcfr_pkg::result_t                  res_reg;
    logic                                res_emit;
    crcfr_pkg::result_t                  res_next;

    logic                                in_acc;
    logic [crcfr_pkg::BYTE_W-1:0]        b;
    logic [crcfr_pkg::LEN_W-1:0]         full_len;
    logic [crcfr_pkg::LEN_W-1:0]         offset;
    logic [crcfr_pkg::LEN_W-1:0]         left_dec;

    // Take a new byte whenever the result register is empty or drains this cycle.
    assign byte_ch.ready = !res_valid_reg || result_ch.ready;
    assign in_acc        = byte_ch.valid && byte_ch.ready;
    assign b             = byte_ch.in_byte;

    assign full_len = {length_reg[crcfr_pkg::LEN_W-1:8], b};
    assign offset   = length_reg - left_reg;
    assign left_dec = left_reg - 16'd1;

    // Next frame state and the result, if any, caused by the byte on the input.
    always_comb
    begin
        phase_next  = phase_reg;
        length_next = length_reg;
        left_next   = left_reg;
        crc_next    = crc_reg;
        rx_crc_next = rx_crc_reg;
        code_next   = code_reg;
        args_next   = args_reg;
        array_next  = array_reg;
        res_emit    = 1'b0;
        res_next    = '0;

        case (phase_reg)
            PH_LEN_HI:
            begin
                length_next = {b, 8'h00};
                phase_next  = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                length_next = full_len;
                if (({1'b0, full_len} + crcfr_pkg::FRAME_OVERHEAD) > max_frame_reg)
                begin
                    // oversize frame: report and drop back to hunting
                    res_emit         = 1'b1;
                    res_next.status  = crcfr_pkg::ST_TOO_LONG;
                    res_next.pay_len = full_len;
                    phase_next       = PH_HUNT;
                end
                else
                begin
                    crc_next    = crcfr_pkg::CRC_INIT;
                    rx_crc_next = '0;
                    code_next   = '0;
                    args_next   = '0;
                    array_next  = '0;
                    if (full_len == '0)
                    begin
                        left_next  = crcfr_pkg::CRC_BYTES;
                        phase_next = PH_CRC;
                    end
                    else
                    begin
                        left_next  = full_len;
                        phase_next = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD:
            begin
                // capture head fields from the first five payload bytes
                case (offset)
                    16'd0:   code_next  = {b, code_reg[7:0]};
                    16'd1:   code_next  = {code_reg[15:8], b};
                    16'd2:   args_next  = b;
                    16'd3:   array_next = {b, array_reg[7:0]};
                    16'd4:   array_next = {array_reg[15:8], b};
                    default: code_next  = code_reg;
                endcase
                crc_next = crcfr_pkg::crc_byte(crc_reg, b);
                if (left_dec == '0)
                begin
                    left_next  = crcfr_pkg::CRC_BYTES;
                    phase_next = PH_CRC;
                end
                else
                begin
                    left_next = left_dec;
                end
                res_emit            = 1'b1;
                res_next.out_byte   = b;
                res_next.is_payload = 1'b1;
                res_next.pay_len    = length_reg;
            end
            PH_CRC:
            begin
                rx_crc_next = {rx_crc_reg[23:0], b};
                left_next   = left_dec;
                if (left_dec == '0)
                begin
                    phase_next = PH_END;
                end
            end
            PH_END:
            begin
                res_emit = 1'b1;
                if (b != crcfr_pkg::END_BYTE)
                begin
                    res_next.status = crcfr_pkg::ST_END_BAD;
                end
                else if (rx_crc_reg != ~crc_reg)
                begin
                    res_next.status = crcfr_pkg::ST_CRC_BAD;
                end
                else if (args_reg > max_args_reg || array_reg > max_array_reg)
                begin
                    res_next.status = crcfr_pkg::ST_OVERFLOW;
                end
                else
                begin
                    res_next.status = crcfr_pkg::ST_OK;
                end
                res_next.frame_code  = code_reg;
                res_next.arg_count   = args_reg;
                res_next.array_count = array_reg;
                res_next.pay_len     = length_reg;
                phase_next           = PH_HUNT;
            end
            default:
            begin
                // hunting, and any unused phase code
                if (b == crcfr_pkg::START_BYTE)
                begin
                    phase_next = PH_LEN_HI;
                end
                else
                begin
                    res_emit        = 1'b1;
                    res_next.status = crcfr_pkg::ST_START_BAD;
                    phase_next      = PH_HUNT;
                end
            end
        endcase
    end

    // Hold frame state, configuration and the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HUNT;
            length_reg    <= '0;
            left_reg      <= '0;
            crc_reg       <= crcfr_pkg::CRC_INIT;
            rx_crc_reg    <= '0;
            code_reg      <= '0;
            args_reg      <= '0;
            array_reg     <= '0;
            max_frame_reg <= crcfr_pkg::MAX_FRAME_RST;
            max_args_reg  <= crcfr_pkg::MAX_ARGS_RST;
            max_array_reg <= crcfr_pkg::MAX_ARRAY_RST;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    crcfr_pkg::CFG_MAX_FRAME: max_frame_reg <= cfg_data;
                    crcfr_pkg::CFG_MAX_ARGS:  max_args_reg  <= cfg_data[7:0];
                    crcfr_pkg::CFG_MAX_ARRAY: max_array_reg <= cfg_data[15:0];
                    default:                  max_frame_reg <= max_frame_reg;
                endcase
            end

            if (in_acc)
            begin
                phase_reg  <= phase_next;
                length_reg <= length_next;
                left_reg   <= left_next;
                crc_reg    <= crc_next;
                rx_crc_reg <= rx_crc_next;
                code_reg   <= code_next;
                args_reg   <= args_next;
                array_reg  <= array_next;
            end

            // Load a fresh result, or drop the old one once the sink takes it.
            if (in_acc && res_emit)
            begin
                res_valid_reg <= 1'b1;
                res_reg       <= res_next;
            end
            else if (result_ch.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    assign result_ch.valid       = res_valid_reg;
    assign result_ch.out_byte    = res_reg.out_byte;
    assign result_ch.is_payload  = res_reg.is_payload;
    assign result_ch.status      = res_reg.status;
    assign result_ch.frame_code  = res_reg.frame_code;
    assign result_ch.arg_count   = res_reg.arg_count;
    assign result_ch.array_count = res_reg.array_count;
    assign result_ch.pay_len     = res_reg.pay_len;

    // A payload byte always yields a payload transaction on the next cycle.
    a_payload_forwarded: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && phase_reg == PH_PAYLOAD) |=> (res_valid_reg && res_reg.is_payload))
        else $error("payload byte not forwarded");

    // Payload transactions carry an ok status and no head fields.
    a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.is_payload) |->
            (res_reg.status == crcfr_pkg::ST_OK && res_reg.frame_code == '0 &&
             res_reg.arg_count == '0 && res_reg.array_count == '0))
        else $error("payload transaction carries status fields");

    // Byte counter never sits at zero while payload or CRC bytes are expected.
    a_left_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PAYLOAD || phase_reg == PH_CRC) |-> (left_reg != '0))
        else $error("byte counter empty inside frame");

    // A result waiting on a stalled sink is never overwritten.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !result_ch.ready) |-> !byte_ch.ready)
        else $error("input accepted while result stalled");

endmodule

`default_nettype wire
